>>> src/buddy_map_merge_engine_assert.svh
// Assertion macros shared by the buddy map merge engine RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BUDDY_MAP_MERGE_ENGINE_ASSERT_SVH
`define BUDDY_MAP_MERGE_ENGINE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define BMME_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BMME_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> src/bmme_pkg.sv
// Package for the buddy map merge engine: payload words, map and run
// counter control structs, command and state enums. No dependencies.
`default_nettype none

package bmme_pkg;

  // Walk positions: wide enough for a pair base plus the largest span.
  localparam int unsigned POS_W      = 18;
  // Run length in units and its rounded-up log2.
  localparam int unsigned RUN_W      = 12;
  localparam int unsigned ORD_W      = 4;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ORDER  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_UNITS = 1'b1;

  localparam logic [4:0]       MIN_ORDER_RST  = 5'd4;
  localparam logic [10:0]      HEAP_UNITS_RST = 11'd1024;
  localparam logic [4:0]       MAX_PAIR_SHIFT = 5'd17;
  localparam logic [4:0]       ORDER_SAT      = 5'd31;
  // Longest possible run is 2047 units.
  localparam logic [ORD_W-1:0] RUN_ORDER_MAX  = 4'd11;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_MEASURE = 2'd2,
    CMD_MERGE   = 2'd3
  } bmme_cmd_e;

  typedef struct packed {
    bmme_cmd_e  cmd;
    logic [9:0] unit_index;
    logic       start_mark_in;
    logic       used_mark_in;
    logic [4:0] merge_order;
  } bmme_in_t;

  typedef struct packed {
    logic       start_mark_out;
    logic       used_mark_out;
    logic [4:0] size_order;
    logic       merge_status;
  } bmme_out_t;

  typedef struct packed {
    logic start;
    logic used;
  } bmme_mark_t;

  typedef struct packed {
    logic             we;
    logic [POS_W-1:0] waddr;
    bmme_mark_t       wdata;
    logic             re;
    logic [POS_W-1:0] raddr;
  } bmme_ram_req_t;

  typedef struct packed {
    logic clr;
    logic step;
  } bmme_run_ctl_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_MEAS,
    ST_PAIR,
    ST_HEAD_CHK,
    ST_WALK,
    ST_RESP
  } bmme_state_e;

endpackage

`default_nettype wire

>>> src/bmme_map_ram.sv
// Unit map store: one write port, one read port, registered read data.
// Depends on bmme_pkg.
`default_nettype none

module bmme_map_ram #(
  parameter int unsigned MAX_UNITS = 1024
) (
  input  wire                      clk_i,
  input  bmme_pkg::bmme_ram_req_t  req_i,
  output bmme_pkg::bmme_mark_t     rdata_o
);

  localparam int unsigned AW = $clog2(MAX_UNITS);

  bmme_pkg::bmme_mark_t mem_q [MAX_UNITS];
  bmme_pkg::bmme_mark_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> src/bmme_run_counter.sv
// Run length counter: counts units of a block and tracks ceil(log2(n)).
// Depends on bmme_pkg and the assertion macro header.
`default_nettype none
`include "buddy_map_merge_engine_assert.svh"

module bmme_run_counter (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  bmme_pkg::bmme_run_ctl_t          ctl_i,
  output logic [bmme_pkg::ORD_W-1:0]       ord_o
);

  localparam int unsigned RW = bmme_pkg::RUN_W;
  localparam int unsigned OW = bmme_pkg::ORD_W;

  logic [RW-1:0] n_q, n_d;
  logic [OW-1:0] c_q, c_d;
  logic          pow2;

  // ceil(log2(n+1)) = ceil(log2(n)) + 1 exactly when n is a power of two
  assign pow2 = ((n_q & (n_q - RW'(1))) == '0);

  always_comb begin
    n_d = n_q;
    c_d = c_q;
    if (ctl_i.clr) begin
      n_d = RW'(1);
      c_d = '0;
    end else if (ctl_i.step) begin
      n_d = n_q + RW'(1);
      if (pow2) begin
        c_d = c_q + OW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= RW'(1);
      c_q <= '0;
    end else begin
      n_q <= n_d;
      c_q <= c_d;
    end
  end

  assign ord_o = c_q;

  `BMME_ASSERT(a_run_order_bound, c_q <= bmme_pkg::RUN_ORDER_MAX, "run order out of range")

endmodule

`default_nettype wire

>>> src/bmme_seq.sv
// Command sequencer: clear sweep, mark read/write, block walk, merge pass
// and output register. Depends on bmme_pkg and the assertion macro header.
`default_nettype none
`include "buddy_map_merge_engine_assert.svh"

module bmme_seq #(
  parameter int unsigned MAX_UNITS = 1024
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  bmme_pkg::bmme_in_t              in_data_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output bmme_pkg::bmme_out_t             out_data_o,
  input  wire  [4:0]                      min_order_i,
  input  wire  [10:0]                     units_i,
  output bmme_pkg::bmme_ram_req_t         ram_req_o,
  input  bmme_pkg::bmme_mark_t            ram_rdata_i,
  output bmme_pkg::bmme_run_ctl_t         run_ctl_o,
  input  wire  [bmme_pkg::ORD_W-1:0]      run_ord_i
);

  localparam int unsigned AW = $clog2(MAX_UNITS);
  localparam int unsigned PW = bmme_pkg::POS_W;

  bmme_pkg::bmme_state_e state_q, state_d;
  bmme_pkg::bmme_in_t    item_q, item_d;
  bmme_pkg::bmme_out_t   res_q, res_d;
  bmme_pkg::bmme_out_t   out_q, out_d;
  logic                  out_valid_q, out_valid_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic [PW-1:0]         j_q, j_d;
  logic [PW-1:0]         base_q, base_d;
  logic [PW-1:0]         half_q, half_d;
  logic [4:0]            dm1_q, dm1_d;
  logic                  half_sel_q, half_sel_d;
  logic                  rd_pend_q, rd_pend_d;

  logic [PW-1:0] units_p, idx_p, buddy, head_pos, span;
  logic          in_store;
  logic [4:0]    ord_gap;
  logic          merge_bad;
  logic [5:0]    size_sum;
  logic          capped, hit, ext, more, fit;

  assign units_p  = PW'(units_i);
  assign idx_p    = PW'(item_q.unit_index);
  assign in_store = (32'(item_q.unit_index) < 32'(MAX_UNITS));
  assign buddy    = base_q + half_q;
  assign head_pos = half_sel_q ? buddy : base_q;
  assign span     = half_q << 1;

  assign ord_gap   = in_data_i.merge_order - min_order_i;
  assign merge_bad = (in_data_i.merge_order <= min_order_i) ||
                     (ord_gap > bmme_pkg::MAX_PAIR_SHIFT);

  assign size_sum = {1'b0, min_order_i} + 6'(run_ord_i);

  // walk bookkeeping: data returned this cycle belongs to unit j_q - 1
  assign capped = (item_q.cmd == bmme_pkg::CMD_MERGE) && (5'(run_ord_i) > dm1_q);
  assign hit    = rd_pend_q && ram_rdata_i.start;
  assign ext    = rd_pend_q && !ram_rdata_i.start;
  assign more   = (j_q < units_p);
  assign fit    = !capped && (5'(run_ord_i) == dm1_q);

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    clr_d       = clr_q;
    j_d         = j_q;
    base_d      = base_q;
    half_d      = half_q;
    dm1_d       = dm1_q;
    half_sel_d  = half_sel_q;
    rd_pend_d   = rd_pend_q;
    in_ready_o  = 1'b0;
    ram_req_o   = '0;
    run_ctl_o   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bmme_pkg::ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = PW'(clr_q);
        clr_d           = clr_q + AW'(1);
        if (clr_q == AW'(MAX_UNITS - 1)) begin
          state_d = bmme_pkg::ST_IDLE;
        end
      end
      bmme_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          item_d     = in_data_i;
          res_d      = '0;
          base_d     = '0;
          half_sel_d = 1'b0;
          unique case (in_data_i.cmd)
            bmme_pkg::CMD_WRITE:   state_d = bmme_pkg::ST_WRITE;
            bmme_pkg::CMD_READ:    state_d = bmme_pkg::ST_READ;
            bmme_pkg::CMD_MEASURE: state_d = bmme_pkg::ST_MEAS;
            bmme_pkg::CMD_MERGE: begin
              if (merge_bad) begin
                res_d.merge_status = 1'b1;
                state_d            = bmme_pkg::ST_RESP;
              end else begin
                dm1_d   = ord_gap - 5'd1;
                half_d  = PW'(1) << (ord_gap - 5'd1);
                state_d = bmme_pkg::ST_PAIR;
              end
            end
            default: state_d = bmme_pkg::ST_IDLE;
          endcase
        end
      end
      bmme_pkg::ST_WRITE: begin
        if (in_store) begin
          ram_req_o.we          = 1'b1;
          ram_req_o.waddr       = idx_p;
          ram_req_o.wdata.start = item_q.start_mark_in;
          ram_req_o.wdata.used  = item_q.used_mark_in;
        end
        state_d = bmme_pkg::ST_RESP;
      end
      bmme_pkg::ST_READ: begin
        if (in_store) begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = idx_p;
          state_d         = bmme_pkg::ST_READ_WAIT;
        end else begin
          state_d = bmme_pkg::ST_RESP;
        end
      end
      bmme_pkg::ST_READ_WAIT: begin
        res_d.start_mark_out = ram_rdata_i.start;
        res_d.used_mark_out  = ram_rdata_i.used;
        state_d              = bmme_pkg::ST_RESP;
      end
      bmme_pkg::ST_MEAS: begin
        // a unit past the heap end sees no reads and measures one unit
        run_ctl_o.clr = 1'b1;
        j_d           = idx_p + PW'(1);
        rd_pend_d     = 1'b0;
        state_d       = bmme_pkg::ST_WALK;
      end
      bmme_pkg::ST_PAIR: begin
        if (!half_sel_q && !(buddy < units_p)) begin
          res_d.merge_status = 1'b1;
          state_d            = bmme_pkg::ST_RESP;
        end else begin
          ram_req_o.re    = 1'b1;
          ram_req_o.raddr = head_pos;
          state_d         = bmme_pkg::ST_HEAD_CHK;
        end
      end
      bmme_pkg::ST_HEAD_CHK: begin
        if (ram_rdata_i.start && !ram_rdata_i.used) begin
          run_ctl_o.clr = 1'b1;
          j_d           = head_pos + PW'(1);
          rd_pend_d     = 1'b0;
          state_d       = bmme_pkg::ST_WALK;
        end else begin
          base_d     = base_q + span;
          half_sel_d = 1'b0;
          state_d    = bmme_pkg::ST_PAIR;
        end
      end
      bmme_pkg::ST_WALK: begin
        if (!(capped || hit || (!ext && !more))) begin
          // one map read issued per cycle, result checked in the next cycle
          run_ctl_o.step = ext;
          if (more) begin
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = j_q;
            j_d             = j_q + PW'(1);
            rd_pend_d       = 1'b1;
          end else begin
            rd_pend_d = 1'b0;
          end
        end else begin
          rd_pend_d = 1'b0;
          if (item_q.cmd == bmme_pkg::CMD_MEASURE) begin
            res_d.size_order = size_sum[5] ? bmme_pkg::ORDER_SAT : size_sum[4:0];
            state_d          = bmme_pkg::ST_RESP;
          end else if (fit && !half_sel_q) begin
            half_sel_d = 1'b1;
            state_d    = bmme_pkg::ST_PAIR;
          end else if (fit) begin
            // both halves qualify: drop the buddy's marks
            ram_req_o.we       = 1'b1;
            ram_req_o.waddr    = buddy;
            res_d.merge_status = 1'b0;
            state_d            = bmme_pkg::ST_RESP;
          end else begin
            base_d     = base_q + span;
            half_sel_d = 1'b0;
            state_d    = bmme_pkg::ST_PAIR;
          end
        end
      end
      bmme_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = bmme_pkg::ST_IDLE;
        end
      end
      default: state_d = bmme_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmme_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      half_sel_q  <= 1'b0;
      rd_pend_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      half_sel_q  <= half_sel_d;
      rd_pend_q   <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    res_q  <= res_d;
    out_q  <= out_d;
    j_q    <= j_d;
    base_q <= base_d;
    half_q <= half_d;
    dm1_q  <= dm1_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BMME_ASSERT(a_resp_to_idle, (state_q == bmme_pkg::ST_RESP) && (!out_valid_q || out_ready_i) |=> out_valid_q && (state_q == bmme_pkg::ST_IDLE), "result word not loaded")
  `BMME_ASSERT(a_out_from_resp, $rose(out_valid_q) |-> ($past(state_q) == bmme_pkg::ST_RESP), "result word from wrong state")
  `BMME_ASSERT_RST(a_reset_clears, !rst_ni |=> (state_q == bmme_pkg::ST_CLEAR), "map sweep skipped after reset")

endmodule

`default_nettype wire

>>> src/buddy_map_merge_engine.sv
// Top level of the buddy map merge engine: configuration registers, heap
// extent clamp, sequencer, run counter and unit map store. Uses bmme_pkg.
//
// The engine keeps a map of MAX_UNITS heap units (start mark, used mark)
// and serves one command word at a time: write marks, read marks, measure
// the block at a unit (rounded-up log2 of its byte size), or one merge
// pass for a given order. Right after reset the map is swept to zero, one
// entry per cycle, so in_ready_o stays low until the sweep ends; the
// configuration port takes writes at any time and must only be written
// while the engine is idle. All work goes through a single map read port
// walked by the sequencer: a measure reads the units after the given one
// until the next block start or the heap end (none for a unit at or past
// the heap end), and a merge pass checks the head of each pair (low half,
// then buddy) and walks the run behind each free head. One result word is
// produced per command word; the output is registered, so the next command
// word is taken while a result still waits for out_ready_i, and the engine
// only holds off its answer while that earlier word is still unread.
`default_nettype none

module buddy_map_merge_engine #(
  parameter int unsigned MAX_UNITS = 1024
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  bmme_pkg::bmme_in_t                     in_data_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output bmme_pkg::bmme_out_t                    out_data_o,
  input  wire                                    cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire  [bmme_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire  [bmme_pkg::CFG_DATA_W-1:0]        cfg_data_i
);

  logic [4:0]  min_order_q, min_order_d;
  logic [10:0] heap_units_q, heap_units_d;
  logic [10:0] units;

  bmme_pkg::bmme_ram_req_t ram_req;
  bmme_pkg::bmme_mark_t    ram_rdata;
  bmme_pkg::bmme_run_ctl_t run_ctl;
  logic [bmme_pkg::ORD_W-1:0] run_ord;

  // config writes are always taken
  assign cfg_ready_o = 1'b1;

  always_comb begin
    min_order_d  = min_order_q;
    heap_units_d = heap_units_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        bmme_pkg::CFG_MIN_ORDER:  min_order_d  = cfg_data_i[4:0];
        bmme_pkg::CFG_HEAP_UNITS: heap_units_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_order_q  <= bmme_pkg::MIN_ORDER_RST;
      heap_units_q <= bmme_pkg::HEAP_UNITS_RST;
    end else begin
      min_order_q  <= min_order_d;
      heap_units_q <= heap_units_d;
    end
  end

  // heap extent beyond the store acts as the store size
  assign units = (32'(heap_units_q) > 32'(MAX_UNITS)) ? 11'(MAX_UNITS) : heap_units_q;

  bmme_seq #(
    .MAX_UNITS (MAX_UNITS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .min_order_i (min_order_q),
    .units_i     (units),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .run_ctl_o   (run_ctl),
    .run_ord_i   (run_ord)
  );

  bmme_run_counter u_run (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (run_ctl),
    .ord_o  (run_ord)
  );

  bmme_map_ram #(
    .MAX_UNITS (MAX_UNITS)
  ) u_map (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

endmodule

`default_nettype wire
